@@ sv/radix_tree_flat_lookup_assert.svh @@
`ifndef RADIX_TREE_FLAT_LOOKUP_ASSERT_SVH
`define RADIX_TREE_FLAT_LOOKUP_ASSERT_SVH

// Check an implication in the same cycle, clocked on clk_i, off during reset.
`define RTFL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, clocked on clk_i, off during reset.
`define RTFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rtfl_pkg.sv @@
package rtfl_pkg;

  // Default table and query buffer sizes
  localparam int unsigned NODE_COUNT_DFLT = 1024;
  localparam int unsigned QUERY_MAX_DFLT  = 256;

  // Payload field widths
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned SKIP_W = 8;
  localparam int unsigned SUB_W  = 10;
  localparam int unsigned VAL_W  = 16;

  // Value reported when no node matches
  localparam logic [VAL_W-1:0] NOT_FOUND_VALUE = '1;

  typedef enum logic {
    ACT_NODE_WR = 1'b0,
    ACT_QUERY   = 1'b1
  } action_e;

  // One node table entry
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [SKIP_W-1:0] skip;
    logic [SUB_W-1:0]  subtree;
    logic [VAL_W-1:0]  value;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } reply_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_CHILD,
    ST_REPLY
  } walk_state_e;

endpackage

@@ sv/rtfl_in_if.sv @@
interface rtfl_in_if;
  import rtfl_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  node_index;
  logic [CHAR_W-1:0] node_char;
  logic [SKIP_W-1:0] node_skip;
  logic [SUB_W-1:0]  node_subtree;
  logic [VAL_W-1:0]  node_value;
  logic [CHAR_W-1:0] query_char;
  logic              query_last;

  modport source (
    output valid, action, node_index, node_char, node_skip, node_subtree, node_value,
    output query_char, query_last,
    input  ready
  );

  modport sink (
    input  valid, action, node_index, node_char, node_skip, node_subtree, node_value,
    input  query_char, query_last,
    output ready
  );

endinterface

@@ sv/rtfl_out_if.sv @@
interface rtfl_out_if;
  import rtfl_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] result_value;

  modport source (
    output valid, found, result_value,
    input  ready
  );

  modport sink (
    input  valid, found, result_value,
    output ready
  );

endinterface

@@ sv/rtfl_ram.sv @@
module rtfl_ram #(
  parameter  int unsigned DATA_W = 8,
  parameter  int unsigned DEPTH  = 4,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/rtfl_walk.sv @@
`include "radix_tree_flat_lookup_assert.svh"

module rtfl_walk #(
  parameter  int unsigned NODE_COUNT = rtfl_pkg::NODE_COUNT_DFLT,
  parameter  int unsigned QUERY_MAX  = rtfl_pkg::QUERY_MAX_DFLT,
  localparam int unsigned NAW        = $clog2(NODE_COUNT),
  localparam int unsigned QAW        = $clog2(QUERY_MAX)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rtfl_in_if.sink                       in_if,
  rtfl_out_if.source                    out_if,
  // node table port
  output logic                          node_wr_en_o,
  output logic [NAW-1:0]                node_wr_addr_o,
  output rtfl_pkg::node_t               node_wr_data_o,
  output logic                          node_rd_en_o,
  output logic [NAW-1:0]                node_rd_addr_o,
  input  rtfl_pkg::node_t               node_rd_data_i,
  // query buffer port
  output logic                          q_wr_en_o,
  output logic [QAW-1:0]                q_wr_addr_o,
  output logic [rtfl_pkg::CHAR_W-1:0]   q_wr_data_o,
  output logic                          q_rd_en_o,
  output logic [QAW-1:0]                q_rd_addr_o,
  input  logic [rtfl_pkg::CHAR_W-1:0]   q_rd_data_i
);
  import rtfl_pkg::*;

  // Table positions, wide enough for node + subtree + 1 past the end
  localparam int unsigned CW  = ((NAW > IDX_W) ? NAW : IDX_W) + 2;
  // Query length and query position (position may run a skip past the length)
  localparam int unsigned QLW = $clog2(QUERY_MAX + 1);
  localparam int unsigned PW  = ((QLW > SKIP_W) ? QLW : SKIP_W) + 1;

  walk_state_e     state_q, state_d;
  logic [QLW-1:0]  qlen_q, qlen_d;
  logic            ovf_q, ovf_d;
  logic [QLW-1:0]  len_q, len_d;
  logic [CW-1:0]   node_q, node_d;
  logic [CW-1:0]   child_q, child_d;
  logic [CW-1:0]   last_q, last_d;
  logic [PW-1:0]   pos_q, pos_d;
  reply_t          reply_q, reply_d;
  logic            out_valid_q, out_valid_d;
  reply_t          out_q, out_d;

  logic            in_fire;
  logic            is_query;
  logic            room;
  logic            slot_free;
  logic [PW-1:0]   pos_skip;
  logic [PW-1:0]   len_ext;
  logic [CW-1:0]   child_first;
  logic [CW-1:0]   last_first;
  logic [CW-1:0]   child_next;

  // Take input only between walks
  assign in_if.ready = (state_q == ST_IDLE);

  assign in_fire   = in_if.valid && in_if.ready;
  assign is_query  = (action_e'(in_if.action) == ACT_QUERY);
  assign room      = (qlen_q < QLW'(QUERY_MAX));
  assign slot_free = !out_valid_q || out_if.ready;

  // Walk arithmetic on the entry just read
  assign len_ext     = PW'(len_q);
  assign pos_skip    = pos_q + PW'(node_rd_data_i.skip);
  assign child_first = node_q + CW'(1);
  assign last_first  = node_q + CW'(node_rd_data_i.subtree);
  assign child_next  = child_q + CW'(node_rd_data_i.subtree) + CW'(1);

  // Node writes go straight to the table, out-of-range indexes dropped
  assign node_wr_en_o   = in_fire && !is_query && (32'(in_if.node_index) < NODE_COUNT);
  assign node_wr_addr_o = NAW'(in_if.node_index);
  assign node_wr_data_o = '{ch:      in_if.node_char,
                            skip:    in_if.node_skip,
                            subtree: in_if.node_subtree,
                            value:   in_if.node_value};

  // Query bytes append to the buffer while there is room
  assign q_wr_en_o   = in_fire && is_query && room;
  assign q_wr_addr_o = qlen_q[QAW-1:0];
  assign q_wr_data_o = in_if.query_char;

  // Next state and memory reads
  always_comb begin
    state_d      = state_q;
    qlen_d       = qlen_q;
    ovf_d        = ovf_q;
    len_d        = len_q;
    node_d       = node_q;
    child_d      = child_q;
    last_d       = last_q;
    pos_d        = pos_q;
    reply_d      = reply_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_d        = out_q;
    node_rd_en_o   = 1'b0;
    node_rd_addr_o = '0;
    q_rd_en_o      = 1'b0;
    q_rd_addr_o    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          if (!in_if.query_last) begin
            qlen_d = room ? qlen_q + QLW'(1) : qlen_q;
            ovf_d  = ovf_q || !room;
          end else begin
            qlen_d = '0;
            ovf_d  = 1'b0;
            if (ovf_q || !room) begin
              reply_d = '{found: 1'b0, value: NOT_FOUND_VALUE};
              state_d = ST_REPLY;
            end else begin
              // Start at the root
              len_d          = qlen_q + QLW'(1);
              node_d         = '0;
              pos_d          = '0;
              node_rd_en_o   = 1'b1;
              node_rd_addr_o = '0;
              state_d        = ST_NODE;
            end
          end
        end
      end

      ST_NODE: begin
        if (node_rd_data_i.subtree == '0) begin
          // Leaf ends the walk
          reply_d = '{found: 1'b1, value: node_rd_data_i.value};
          state_d = ST_REPLY;
        end else if (pos_skip == len_ext) begin
          reply_d = '{found: 1'b1, value: node_rd_data_i.value};
          state_d = ST_REPLY;
        end else if (pos_skip > len_ext || child_first >= CW'(NODE_COUNT)) begin
          reply_d = '{found: 1'b0, value: NOT_FOUND_VALUE};
          state_d = ST_REPLY;
        end else begin
          // Fetch the first child and the query byte at the new position
          pos_d          = pos_skip;
          child_d        = child_first;
          last_d         = last_first;
          node_rd_en_o   = 1'b1;
          node_rd_addr_o = child_first[NAW-1:0];
          q_rd_en_o      = 1'b1;
          q_rd_addr_o    = pos_skip[QAW-1:0];
          state_d        = ST_CHILD;
        end
      end

      ST_CHILD: begin
        if (node_rd_data_i.ch == q_rd_data_i) begin
          // Descend; the child's entry is already in the read register
          node_d  = child_q;
          pos_d   = pos_q + PW'(1);
          state_d = ST_NODE;
        end else if (child_next <= last_q && child_next < CW'(NODE_COUNT)) begin
          // Jump over this child's subtree to its next sibling
          child_d        = child_next;
          node_rd_en_o   = 1'b1;
          node_rd_addr_o = child_next[NAW-1:0];
        end else begin
          reply_d = '{found: 1'b0, value: NOT_FOUND_VALUE};
          state_d = ST_REPLY;
        end
      end

      ST_REPLY: begin
        // Hand the reply to the output register once it is free
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = reply_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      qlen_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      qlen_q      <= qlen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    node_q  <= node_d;
    child_q <= child_d;
    last_q  <= last_d;
    pos_q   <= pos_d;
    reply_q <= reply_d;
    out_q   <= out_d;
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.found        = out_q.found;
  assign out_if.result_value = out_q.value;

  `RTFL_ASSERT_IMPL(a_no_table_rw_clash, node_wr_en_o, !node_rd_en_o,
                    "node table read and written in one cycle")
  `RTFL_ASSERT_IMPL(a_qlen_bound, 1'b1, qlen_q <= QLW'(QUERY_MAX),
                    "query length beyond buffer size")
  `RTFL_ASSERT_IMPL(a_child_in_range, state_q == ST_CHILD,
                    child_q <= last_q && child_q < CW'(NODE_COUNT),
                    "child scan left the subtree or the table")
  `RTFL_ASSERT_IMPL(a_pos_in_query, state_q == ST_CHILD, pos_q < len_ext,
                    "child compare past the end of the query")
  `RTFL_ASSERT_NEXT(a_walk_starts_at_root,
                    state_q == ST_IDLE && node_rd_en_o,
                    state_q == ST_NODE && node_q == '0 && pos_q == '0,
                    "walk did not start at the root")

endmodule

@@ sv/radix_tree_flat_lookup.sv @@
// Patricia trie lookup over a pre-order node table.
// Input channel (in_if): action 0 transfers one node entry into the table at
// node_index (indexes at or beyond NODE_COUNT are dropped); action 1 transfers
// one query byte into the query buffer. The byte with query_last set starts a
// walk from node 0; bytes beyond QUERY_MAX are dropped and the query reports
// not found. Output channel (out_if): one result per query, found plus the
// node value, or found 0 with value 0xFFFF.
// Node writes and query bytes are taken whenever the block is idle. After the
// last byte is transferred the walk reads the root entry, then visits nodes
// and compares child entries against the query bytes, each step being one
// read of the single read port of the node table. Input ready is low while
// a walk is in progress.
// The result sits in an output register; a stalled receiver holds it, a walk
// that finishes meanwhile waits in its reply state, and node writes and query
// bytes keep being taken while the block is idle.
// Reset clears the query length, the overflow flag, the walk state and the
// output valid. The node table and the query buffer are not cleared; a walk
// must only reach entries that were written.
module radix_tree_flat_lookup #(
  parameter int unsigned NODE_COUNT = rtfl_pkg::NODE_COUNT_DFLT,
  parameter int unsigned QUERY_MAX  = rtfl_pkg::QUERY_MAX_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtfl_in_if.sink    in_if,
  rtfl_out_if.source out_if
);
  import rtfl_pkg::*;

  localparam int unsigned NAW = $clog2(NODE_COUNT);
  localparam int unsigned QAW = $clog2(QUERY_MAX);

  logic              node_wr_en;
  logic [NAW-1:0]    node_wr_addr;
  node_t             node_wr_data;
  logic              node_rd_en;
  logic [NAW-1:0]    node_rd_addr;
  node_t             node_rd_data;
  logic              q_wr_en;
  logic [QAW-1:0]    q_wr_addr;
  logic [CHAR_W-1:0] q_wr_data;
  logic              q_rd_en;
  logic [QAW-1:0]    q_rd_addr;
  logic [CHAR_W-1:0] q_rd_data;

  // Node table
  rtfl_ram #(
    .DATA_W (NODE_W),
    .DEPTH  (NODE_COUNT)
  ) u_node_tbl (
    .clk_i     (clk_i),
    .wr_en_i   (node_wr_en),
    .wr_addr_i (node_wr_addr),
    .wr_data_i (node_wr_data),
    .rd_en_i   (node_rd_en),
    .rd_addr_i (node_rd_addr),
    .rd_data_o (node_rd_data)
  );

  // Query byte buffer
  rtfl_ram #(
    .DATA_W (CHAR_W),
    .DEPTH  (QUERY_MAX)
  ) u_query_buf (
    .clk_i     (clk_i),
    .wr_en_i   (q_wr_en),
    .wr_addr_i (q_wr_addr),
    .wr_data_i (q_wr_data),
    .rd_en_i   (q_rd_en),
    .rd_addr_i (q_rd_addr),
    .rd_data_o (q_rd_data)
  );

  // Buffer control and trie walk sequencer
  rtfl_walk #(
    .NODE_COUNT (NODE_COUNT),
    .QUERY_MAX  (QUERY_MAX)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .out_if         (out_if),
    .node_wr_en_o   (node_wr_en),
    .node_wr_addr_o (node_wr_addr),
    .node_wr_data_o (node_wr_data),
    .node_rd_en_o   (node_rd_en),
    .node_rd_addr_o (node_rd_addr),
    .node_rd_data_i (node_rd_data),
    .q_wr_en_o      (q_wr_en),
    .q_wr_addr_o    (q_wr_addr),
    .q_wr_data_o    (q_wr_data),
    .q_rd_en_o      (q_rd_en),
    .q_rd_addr_o    (q_rd_addr),
    .q_rd_data_i    (q_rd_data)
  );

endmodule
